### design/swnf_pkg.sv
package swnf_pkg;

    localparam int MAX_ENTITIES = 64;
    localparam int COORD_BITS   = 16;

    localparam int ID_W   = 16;
    localparam int SLOT_W = 6;
    localparam int RAD_W  = 16;
    localparam int RAW_W  = 16;
    localparam int IDX_W  = $clog2(MAX_ENTITIES);
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int CMP_W  = (DIFF_W > RAD_W) ? DIFF_W : RAD_W;

    localparam int REQ_DEPTH = 2;
    localparam int REQ_PTR_W = $clog2(REQ_DEPTH);
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);

    typedef enum logic [1:0] {
        CMD_ENTER = 2'd0,
        CMD_MOVE  = 2'd1,
        CMD_LEAVE = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        OP_ACK,
        OP_ENTER,
        OP_MOVE,
        OP_LEAVE
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_op               op;
        logic [IDX_W-1:0]  slot;
        logic [ID_W-1:0]   id;
        t_coord            x;
        t_coord            y;
        logic [RAD_W-1:0]  radius;
    } t_req;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [SLOT_W-1:0] slot;
        logic              found;
        logic              last;
    } t_res;

    function automatic t_coord to_coord(input logic [RAW_W-1:0] raw);
        logic [COORD_BITS+RAW_W-1:0] ext;
        ext = {{COORD_BITS{raw[RAW_W-1]}}, raw};
        return t_coord'(ext[COORD_BITS-1:0]);
    endfunction

endpackage

### design/square_window_neighbor_finder.sv
// channel    handshake          payload
// request    push / full        i_cmd i_slot i_entity_id i_pos_x i_pos_y i_view_radius
// result     empty / pop        o_neighbor_id o_neighbor_slot o_found o_last
//
// Enter and move run a scan in the table unit: write the slot, read the table
// memory once per slot, test the last read, then emit the final result.
// Leave and rejected requests are answered from the idle state with one result.
// Reset is synchronous; the table comes up empty with no clearing pass.
// A full result queue stalls the scan; two requests queue ahead of it.
module square_window_neighbor_finder (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [1:0]                  i_cmd,
    input  logic [swnf_pkg::SLOT_W-1:0] i_slot,
    input  logic [swnf_pkg::ID_W-1:0]   i_entity_id,
    input  logic [swnf_pkg::RAW_W-1:0]  i_pos_x,
    input  logic [swnf_pkg::RAW_W-1:0]  i_pos_y,
    input  logic [swnf_pkg::RAD_W-1:0]  i_view_radius,
    output logic                        empty,
    input  logic                        pop,
    output logic [swnf_pkg::ID_W-1:0]   o_neighbor_id,
    output logic [swnf_pkg::SLOT_W-1:0] o_neighbor_slot,
    output logic                        o_found,
    output logic                        o_last
);
    import swnf_pkg::*;

    logic req_valid;
    t_req req;
    logic req_take;
    logic res_push;
    t_res res;
    logic res_full;
    t_res head;

    swnf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_cmd         (i_cmd),
        .i_slot        (i_slot),
        .i_entity_id   (i_entity_id),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_view_radius (i_view_radius),
        .o_req_valid   (req_valid),
        .o_req         (req),
        .i_req_take    (req_take)
    );

    swnf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .i_req       (req),
        .o_req_take  (req_take),
        .o_res_push  (res_push),
        .o_res       (res),
        .i_res_full  (res_full)
    );

    swnf_out_q u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_res   (res),
        .o_full  (res_full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_head  (head)
    );

    assign o_neighbor_id   = head.id;
    assign o_neighbor_slot = head.slot;
    assign o_found         = head.found;
    assign o_last          = head.last;

endmodule

### design/swnf_front.sv
module swnf_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    output logic                       o_full,
    input  logic [1:0]                 i_cmd,
    input  logic [swnf_pkg::SLOT_W-1:0] i_slot,
    input  logic [swnf_pkg::ID_W-1:0]  i_entity_id,
    input  logic [swnf_pkg::RAW_W-1:0] i_pos_x,
    input  logic [swnf_pkg::RAW_W-1:0] i_pos_y,
    input  logic [swnf_pkg::RAD_W-1:0] i_view_radius,
    output logic                       o_req_valid,
    output swnf_pkg::t_req             o_req,
    input  logic                       i_req_take
);
    import swnf_pkg::*;

    t_req                 n_req;
    t_req                 r_q [REQ_DEPTH];
    logic [REQ_PTR_W-1:0] r_wp;
    logic [REQ_PTR_W-1:0] r_rp;
    logic [REQ_PTR_W:0]   r_cnt;
    logic                 push_ok;
    logic                 take_ok;

    // classify
    always_comb begin
        n_req.slot   = i_slot[IDX_W-1:0];
        n_req.id     = i_entity_id;
        n_req.x      = to_coord(i_pos_x);
        n_req.y      = to_coord(i_pos_y);
        n_req.radius = i_view_radius;
        case (t_cmd'(i_cmd))
            CMD_ENTER: n_req.op = OP_ENTER;
            CMD_MOVE:  n_req.op = OP_MOVE;
            CMD_LEAVE: n_req.op = OP_LEAVE;
            default:   n_req.op = OP_ACK;
        endcase
        if (int'(i_slot) >= MAX_ENTITIES) begin
            n_req.op = OP_ACK;
        end
    end

    assign o_full      = (r_cnt == (REQ_PTR_W+1)'(REQ_DEPTH));
    assign o_req_valid = (r_cnt != '0);
    assign o_req       = r_q[r_rp];
    assign push_ok     = i_push && !o_full;
    assign take_ok     = i_req_take && o_req_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wp <= r_wp + 1'b1;
            end
            if (take_ok) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({push_ok, take_ok})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wp] <= n_req;
        end
    end

endmodule

### design/swnf_back.sv
module swnf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  swnf_pkg::t_req i_req,
    output logic           o_req_take,
    output logic           o_res_push,
    output swnf_pkg::t_res o_res,
    input  logic           i_res_full
);
    import swnf_pkg::*;

    t_state                  r_state;
    t_state                  n_state;
    logic [MAX_ENTITIES-1:0] r_valid;

    logic [ID_W-1:0]         r_mem_id [MAX_ENTITIES];
    t_coord                  r_mem_x  [MAX_ENTITIES];
    t_coord                  r_mem_y  [MAX_ENTITIES];

    logic [IDX_W-1:0]        r_self;
    t_coord                  r_self_x;
    t_coord                  r_self_y;
    logic [RAD_W-1:0]        r_radius;

    logic                    r_issue;
    logic [IDX_W-1:0]        r_idx;
    logic                    r_s1_v;
    logic                    r_s1_last;
    logic [IDX_W-1:0]        r_s1_idx;
    logic [ID_W-1:0]         r_rd_id;
    t_coord                  r_rd_x;
    t_coord                  r_rd_y;

    logic                    r_pend_v;
    logic [ID_W-1:0]         r_pend_id;
    logic [IDX_W-1:0]        r_pend_slot;

    logic                    adv;
    logic                    start;
    logic                    wr_id;
    logic                    wr_pos;
    logic                    set_v;
    logic                    clr_v;
    logic                    rd_en;
    logic                    s1_fire;
    logic                    hit;
    logic                    win_x;
    logic                    win_y;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic [DIFF_W-1:0]       adx;
    logic [DIFF_W-1:0]       ady;

    assign adv = !i_res_full;

    // window test on the slot held in the read registers
    always_comb begin
        dx    = DIFF_W'(r_rd_x) - DIFF_W'(r_self_x);
        dy    = DIFF_W'(r_rd_y) - DIFF_W'(r_self_y);
        adx   = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
        ady   = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
        win_x = CMP_W'(adx) <= CMP_W'(r_radius);
        win_y = CMP_W'(ady) <= CMP_W'(r_radius);
        hit   = r_s1_v && r_valid[r_s1_idx] && (r_s1_idx != r_self) && win_x && win_y;
    end

    always_comb begin
        o_req_take = 1'b0;
        o_res_push = 1'b0;
        o_res      = '0;
        o_res.last = 1'b1;
        start      = 1'b0;
        wr_id      = 1'b0;
        wr_pos     = 1'b0;
        set_v      = 1'b0;
        clr_v      = 1'b0;
        rd_en      = 1'b0;
        s1_fire    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    case (i_req.op)
                        OP_ENTER: begin
                            o_req_take = 1'b1;
                            start      = 1'b1;
                            wr_id      = 1'b1;
                            wr_pos     = 1'b1;
                            set_v      = 1'b1;
                        end
                        OP_MOVE: begin
                            if (r_valid[i_req.slot]) begin
                                o_req_take = 1'b1;
                                start      = 1'b1;
                                wr_pos     = 1'b1;
                            end else if (adv) begin
                                o_req_take = 1'b1;
                                o_res_push = 1'b1;
                            end
                        end
                        OP_LEAVE: begin
                            if (adv) begin
                                o_req_take = 1'b1;
                                o_res_push = 1'b1;
                                clr_v      = 1'b1;
                            end
                        end
                        default: begin
                            if (adv) begin
                                o_req_take = 1'b1;
                                o_res_push = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (adv) begin
                    rd_en   = r_issue;
                    s1_fire = r_s1_v;
                    if (r_s1_v && hit && r_pend_v) begin
                        o_res_push  = 1'b1;
                        o_res.id    = r_pend_id;
                        o_res.slot  = SLOT_W'(r_pend_slot);
                        o_res.found = 1'b1;
                        o_res.last  = 1'b0;
                    end
                end
            end
            ST_FINISH: begin
                if (adv) begin
                    o_res_push = 1'b1;
                    if (r_pend_v) begin
                        o_res.id    = r_pend_id;
                        o_res.slot  = SLOT_W'(r_pend_slot);
                        o_res.found = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (s1_fire && r_s1_last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (adv) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_valid  <= '0;
            r_issue  <= 1'b0;
            r_s1_v   <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            r_state <= n_state;
            if (set_v) begin
                r_valid[i_req.slot] <= 1'b1;
            end
            if (clr_v) begin
                r_valid[i_req.slot] <= 1'b0;
            end
            if (start) begin
                r_issue  <= 1'b1;
                r_s1_v   <= 1'b0;
                r_pend_v <= 1'b0;
            end else if (r_state == ST_SCAN && adv) begin
                r_s1_v <= r_issue;
                if (r_issue && r_idx == IDX_W'(MAX_ENTITIES - 1)) begin
                    r_issue <= 1'b0;
                end
                if (s1_fire && hit) begin
                    r_pend_v <= 1'b1;
                end
            end else if (r_state == ST_FINISH && adv) begin
                r_pend_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_self   <= i_req.slot;
            r_self_x <= i_req.x;
            r_self_y <= i_req.y;
            r_radius <= i_req.radius;
            r_idx    <= '0;
        end
        if (rd_en) begin
            r_s1_idx  <= r_idx;
            r_s1_last <= (r_idx == IDX_W'(MAX_ENTITIES - 1));
            r_idx     <= r_idx + 1'b1;
        end
        if (s1_fire && hit) begin
            r_pend_id   <= r_rd_id;
            r_pend_slot <= r_s1_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_id) begin
            r_mem_id[i_req.slot] <= i_req.id;
        end
        if (wr_pos) begin
            r_mem_x[i_req.slot] <= i_req.x;
            r_mem_y[i_req.slot] <= i_req.y;
        end
        if (rd_en) begin
            r_rd_id <= r_mem_id[r_idx];
            r_rd_x  <= r_mem_x[r_idx];
            r_rd_y  <= r_mem_y[r_idx];
        end
    end

endmodule

### design/swnf_out_q.sv
module swnf_out_q (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  swnf_pkg::t_res i_res,
    output logic           o_full,
    output logic           o_empty,
    input  logic           i_pop,
    output swnf_pkg::t_res o_head
);
    import swnf_pkg::*;

    t_res                 r_q [RES_DEPTH];
    logic [RES_PTR_W-1:0] r_wp;
    logic [RES_PTR_W-1:0] r_rp;
    logic [RES_PTR_W:0]   r_cnt;
    logic                 push_ok;
    logic                 pop_ok;

    assign o_full  = (r_cnt == (RES_PTR_W+1)'(RES_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_q[r_rp];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop_ok) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({push_ok, pop_ok})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wp] <= i_res;
        end
    end

endmodule

### design/swnf_checker.sv
module swnf_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        push,
    input logic                        full,
    input logic                        empty,
    input logic                        pop,
    input logic [swnf_pkg::ID_W-1:0]   o_neighbor_id,
    input logic [swnf_pkg::SLOT_W-1:0] o_neighbor_slot,
    input logic                        o_found,
    input logic                        o_last
);
    import swnf_pkg::*;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not cleared by reset");

    a_none_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_found) |-> (o_last && o_neighbor_id == '0 && o_neighbor_slot == '0))
        else $error("empty result malformed");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_found) |-> (int'(o_neighbor_slot) < MAX_ENTITIES))
        else $error("neighbor slot out of range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_neighbor_id) && $stable(o_neighbor_slot)
                              && $stable(o_found) && $stable(o_last)))
        else $error("waiting result changed");

endmodule

bind square_window_neighbor_finder swnf_checker u_swnf_checker (.*);
